// File: rtl/dct_pkg.sv
// Package for the dirty chunk tracker: sizes, operation codes and result kinds.
// Used by dirty_chunk_tracker_top; depends on nothing.
package dct_pkg;

  // Geometry of the tracked map
  localparam int CHUNK_BITS = 5;
  localparam int NODE_BITS  = 2;
  localparam int LAYERS     = 16;
  localparam int GRID       = 8;

  localparam int COORD_W  = 16;
  localparam int LAYER_W  = 5;
  localparam int MAP_W    = GRID * GRID;
  localparam int LAYER_AW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int BIT_W    = $clog2(MAP_W);
  localparam int GRID_W   = $clog2(GRID);
  // chunk coordinates after a node shift, plus one bit for window end sums
  localparam int CMP_W    = COORD_W + NODE_BITS + 1;

  typedef logic [2:0] op_t;
  typedef logic [1:0] kind_t;

  // Operation codes
  localparam op_t OP_TILE   = 3'd0;
  localparam op_t OP_NODE   = 3'd1;
  localparam op_t OP_CHUNK  = 3'd2;
  localparam op_t OP_REGION = 3'd3;
  localparam op_t OP_ALL    = 3'd4;
  localparam op_t OP_QUERY  = 3'd5;
  localparam op_t OP_CLEAR  = 3'd6;
  localparam op_t OP_TAKE   = 3'd7;

  // Result kinds
  localparam kind_t KIND_ACK   = 2'd0;
  localparam kind_t KIND_QUERY = 2'd1;
  localparam kind_t KIND_WORD  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_WINDOW_X = 1'b0;
  localparam logic CFG_WINDOW_Y = 1'b1;

endpackage

// File: rtl/dirty_chunk_tracker_top.sv
// Dirty chunk tracker: per-layer dirty bitmap in one synchronous memory.
// Depends on dct_pkg.
//
//   channel  handshake             word
//   in       in_valid / in_stall   operation, x_a, y_a, x_b, y_b, layer
//   out      out_valid / out_stall kind, notified, is_dirty, drained_layer,
//                                  dirty_word, all_dirty, generation, clipped, last
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data (window_x, window_y)
//
// One item at a time: a mark, query, all or clear holds the input through latch,
// window compare plus map read, and merge and write back; its result is registered
// in the merge step, which output stall can hold.
// A take holds the input while it reads the layers in turn, a read step then a word
// step for each: the single map read port gives one layer word at a time.
// in_stall is high while an item runs.
// Output stall holds the result register and the item waiting behind it.
// A one-cycle rst clears the entry valid bits, flags and generation; no sweep.
module dirty_chunk_tracker_top (
  input  logic                         clk,
  input  logic                         rst,
  // item input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dct_pkg::op_t                 operation,
  input  logic [dct_pkg::COORD_W-1:0]  x_a,
  input  logic [dct_pkg::COORD_W-1:0]  y_a,
  input  logic [dct_pkg::COORD_W-1:0]  x_b,
  input  logic [dct_pkg::COORD_W-1:0]  y_b,
  input  logic [dct_pkg::LAYER_W-1:0]  layer,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output dct_pkg::kind_t               kind,
  output logic                         notified,
  output logic                         is_dirty,
  output logic [3:0]                   drained_layer,
  output logic [63:0]                  dirty_word,
  output logic                         all_dirty,
  output logic [31:0]                  generation,
  output logic                         clipped,
  output logic                         last,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [15:0]                  cfg_data
);
  import dct_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_TRD  = 3'd3;
  localparam logic [2:0] S_TWR  = 3'd4;

  logic [2:0] state, state_next;

  // window registers
  logic [COORD_W-1:0] win_x, win_y;

  // flags and counters
  logic              all_flag;
  logic [31:0]       generation_count;
  logic [LAYERS-1:0] map_vld;
  logic [LAYER_AW-1:0] take_idx;

  // latched item
  op_t                 op_q;
  logic [COORD_W-1:0]  xa_q, ya_q;
  logic [LAYER_W-1:0]  lay_q;
  logic [CMP_W-1:0]    x0_q, x1_q, y0_q, y1_q;

  // chunk range of the incoming item
  logic [COORD_W-1:0]  sx, ex, sy, ey;
  logic [CMP_W-1:0]    x0_d, x1_d, y0_d, y1_d;

  // window compare results
  logic [CMP_W-1:0]    wx_lo, wx_hi, wy_lo, wy_hi, cx, cy;
  logic [CMP_W-1:0]    dx, dy;
  logic [GRID-1:0]     col_in, row_in;
  logic [MAP_W-1:0]    mask_d, mask_q;
  logic                clip_d, clip_q;
  logic [BIT_W-1:0]    qbit_d, qbit_q;
  logic                qin_d, qin_q;
  logic                lay_ok;

  // map memory
  logic [MAP_W-1:0]    map_mem [LAYERS];
  logic                rd_en;
  logic [LAYER_AW-1:0] rd_addr;
  logic [MAP_W-1:0]    rd_data;
  logic                rd_vld;
  logic                mem_we;
  logic [MAP_W-1:0]    cur_word, new_word;

  // result assembly
  logic        in_acc, out_free, out_load, take_last, is_mark;
  kind_t       r_kind;
  logic        r_notified, r_is_dirty, r_clipped, r_last;
  logic [3:0]  r_layer;
  logic [63:0] r_word;
  logic [31:0] r_gen;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign take_last = (take_idx == LAYER_AW'(LAYERS - 1));
  assign lay_ok    = ({1'b0, lay_q} < (LAYER_W + 1)'(LAYERS));
  assign is_mark   = (op_q <= OP_REGION);

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_x <= '0;
      win_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_X: win_x <= cfg_data;
        CFG_WINDOW_Y: win_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // chunk range from item coordinates; region corners ordered first
  always_comb begin
    sx = (x_a < x_b) ? x_a : x_b;
    ex = (x_a < x_b) ? x_b : x_a;
    sy = (y_a < y_b) ? y_a : y_b;
    ey = (y_a < y_b) ? y_b : y_a;
    unique case (operation)
      OP_TILE: begin
        x0_d = CMP_W'(x_a) >> CHUNK_BITS;
        y0_d = CMP_W'(y_a) >> CHUNK_BITS;
        x1_d = x0_d;
        y1_d = y0_d;
      end
      OP_NODE: begin
        x0_d = (CMP_W'(x_a) << NODE_BITS) >> CHUNK_BITS;
        y0_d = (CMP_W'(y_a) << NODE_BITS) >> CHUNK_BITS;
        x1_d = x0_d;
        y1_d = y0_d;
      end
      OP_REGION: begin
        x0_d = CMP_W'(sx) >> CHUNK_BITS;
        x1_d = CMP_W'(ex) >> CHUNK_BITS;
        y0_d = CMP_W'(sy) >> CHUNK_BITS;
        y1_d = CMP_W'(ey) >> CHUNK_BITS;
      end
      default: begin
        x0_d = CMP_W'(x_a);
        y0_d = CMP_W'(y_a);
        x1_d = x0_d;
        y1_d = y0_d;
      end
    endcase
  end

  // latch the item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q  <= operation;
      xa_q  <= x_a;
      ya_q  <= y_a;
      lay_q <= layer;
      x0_q  <= x0_d;
      x1_q  <= x1_d;
      y0_q  <= y0_d;
      y1_q  <= y1_d;
    end
  end

  // window compare: column and row hit vectors, clip flag, query bit
  always_comb begin
    wx_lo = CMP_W'(win_x);
    wy_lo = CMP_W'(win_y);
    wx_hi = wx_lo + CMP_W'(GRID - 1);
    wy_hi = wy_lo + CMP_W'(GRID - 1);
    cx    = '0;
    cy    = '0;
    for (int c = 0; c < GRID; c++) begin
      cx        = wx_lo + CMP_W'(c);
      col_in[c] = (cx >= x0_q) && (cx <= x1_q);
    end
    for (int r = 0; r < GRID; r++) begin
      cy        = wy_lo + CMP_W'(r);
      row_in[r] = (cy >= y0_q) && (cy <= y1_q);
    end
    for (int r = 0; r < GRID; r++) begin
      for (int c = 0; c < GRID; c++) begin
        mask_d[r*GRID + c] = row_in[r] & col_in[c];
      end
    end
    clip_d = (x0_q < wx_lo) || (x1_q > wx_hi) || (y0_q < wy_lo) || (y1_q > wy_hi);
    dx     = CMP_W'(xa_q) - wx_lo;
    dy     = CMP_W'(ya_q) - wy_lo;
    qin_d  = (xa_q >= win_x) && (ya_q >= win_y) &&
             (dx < CMP_W'(GRID)) && (dy < CMP_W'(GRID));
    qbit_d = BIT_W'(dy[GRID_W-1:0]) * BIT_W'(GRID) + BIT_W'(dx[GRID_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      mask_q <= mask_d;
      clip_q <= clip_d;
      qbit_q <= qbit_d;
      qin_q  <= qin_d;
    end
  end

  // map memory: one read port, one write port, read data registered
  assign rd_en   = (state == S_CALC) || (state == S_TRD);
  assign rd_addr = (state == S_TRD) ? take_idx : lay_q[LAYER_AW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
      rd_vld  <= map_vld[rd_addr];
    end
  end

  assign cur_word = rd_vld ? rd_data : '0;
  assign new_word = cur_word | mask_q;
  assign mem_we   = (state == S_MOD) && out_free && is_mark && lay_ok && !all_flag;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[lay_q[LAYER_AW-1:0]] <= new_word;
    end
  end

  // result fields for the current step
  always_comb begin
    r_kind     = KIND_ACK;
    r_notified = 1'b0;
    r_is_dirty = 1'b0;
    r_layer    = '0;
    r_word     = '0;
    r_clipped  = 1'b0;
    r_last     = 1'b1;
    r_gen      = generation_count;
    if (state == S_TWR) begin
      r_kind  = KIND_WORD;
      r_layer = 4'(take_idx);
      r_word  = 64'(cur_word);
      r_last  = take_last;
    end else begin
      priority case (1'b1)
        is_mark: begin
          if (lay_ok) begin
            r_notified = 1'b1;
            r_gen      = generation_count + 32'd1;
            r_clipped  = !all_flag && clip_q;
          end
        end
        (op_q == OP_ALL): begin
          r_notified = 1'b1;
          r_gen      = generation_count + 32'd1;
        end
        (op_q == OP_QUERY): begin
          r_kind     = KIND_QUERY;
          r_is_dirty = (!all_flag && lay_ok && qin_q) ? cur_word[qbit_q] : all_flag;
        end
        default: ;
      endcase
    end
  end

  assign out_load = out_free && ((state == S_MOD) || (state == S_TWR));

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc) state_next = S_CALC;
      S_CALC: state_next = (op_q == OP_TAKE) ? S_TRD : S_MOD;
      S_MOD:  if (out_free) state_next = S_IDLE;
      S_TRD:  state_next = S_TWR;
      S_TWR: begin
        if (out_free) state_next = take_last ? S_IDLE : S_TRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state, flags and generation
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      all_flag         <= 1'b0;
      generation_count <= '0;
      map_vld          <= '0;
      take_idx         <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_CALC) begin
        take_idx <= '0;
      end
      if (state == S_MOD && out_free) begin
        generation_count <= r_gen;
        if (mem_we) begin
          map_vld[lay_q[LAYER_AW-1:0]] <= 1'b1;
        end
        if (op_q == OP_ALL) begin
          all_flag <= 1'b1;
          map_vld  <= '0;
        end else if (op_q == OP_CLEAR) begin
          all_flag <= 1'b0;
          map_vld  <= '0;
        end
      end
      if (state == S_TWR && out_free) begin
        take_idx <= take_idx + LAYER_AW'(1);
        if (take_last) begin
          all_flag <= 1'b0;
          map_vld  <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind          <= r_kind;
      notified      <= r_notified;
      is_dirty      <= r_is_dirty;
      drained_layer <= r_layer;
      dirty_word    <= r_word;
      all_dirty     <= all_flag;
      generation    <= r_gen;
      clipped       <= r_clipped;
      last          <= r_last;
    end
  end

  // an accepted item blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("input not stalled after accepting a word");

  // the map is only written while all-dirty is clear, in the merge step
  a_write_merge_only: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_MOD) && !all_flag && lay_ok)
    else $error("map write outside merge step");

  // a finished take leaves an empty map
  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_TWR && out_free && take_last) |=> (map_vld == '0) && !all_flag)
    else $error("map not cleared after take");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dirty_chunk_tracker_top: a queue-fed driver, a
// result monitor and a shadow copy of the dirty map that predicts every word.
// Depends on dct_pkg and the tracker RTL.
module tb_top;
  import dct_pkg::*;

  typedef struct packed {
    op_t         operation;
    logic [15:0] x_a;
    logic [15:0] y_a;
    logic [15:0] x_b;
    logic [15:0] y_b;
    logic [4:0]  layer;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic        notified;
    logic        is_dirty;
    logic [3:0]  drained_layer;
    logic [63:0] dirty_word;
    logic        all_dirty;
    logic [31:0] generation;
    logic        clipped;
    logic        last;
  } result_t;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  op_t         operation = OP_TILE;
  logic [15:0] x_a = '0, y_a = '0, x_b = '0, y_b = '0;
  logic [4:0]  layer = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       kind;
  logic        notified, is_dirty, all_dirty, clipped, last;
  logic [3:0]  drained_layer;
  logic [63:0] dirty_word;
  logic [31:0] generation;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_WINDOW_X;
  logic [15:0] cfg_data = '0;

  // Shadow tracker state
  logic [63:0] shadow_map [LAYERS];
  logic        shadow_all = 1'b0;
  logic [31:0] shadow_gen = '0;
  int unsigned shadow_wx = 0;
  int unsigned shadow_wy = 0;

  cmd_t    pending_cmds [$];
  result_t awaited_results [$];
  cmd_t    cur_cmd;

  int  cmds_queued = 0;
  int  cmds_accepted = 0;
  int  results_checked = 0;
  int  drains_seen = 0;
  int  window_writes = 0;
  int  mismatches = 0;
  int  send_gap = 0;
  int  recv_wait = 0;
  int  recv_next;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  long_hold = 1'b0;
  bit  send_fire;
  bit  quiet_send = 1'b0;
  bit  quiet_recv = 1'b0;

  dirty_chunk_tracker_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .x_a(x_a), .y_a(y_a), .x_b(x_b), .y_b(y_b), .layer(layer),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .notified(notified), .is_dirty(is_dirty), .drained_layer(drained_layer),
    .dirty_word(dirty_word), .all_dirty(all_dirty), .generation(generation),
    .clipped(clipped), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    foreach (shadow_map[i]) shadow_map[i] = '0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void add_result(kind_t k, logic ntf, logic dirty, logic [3:0] dl,
                                     logic [63:0] bits, logic all_prior, logic clip,
                                     logic fin);
    result_t r;
    r.kind = k; r.notified = ntf; r.is_dirty = dirty; r.drained_layer = dl;
    r.dirty_word = bits; r.all_dirty = all_prior; r.generation = shadow_gen;
    r.clipped = clip; r.last = fin;
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic void wipe_map();
    foreach (shadow_map[i]) shadow_map[i] = '0;
    shadow_all = 1'b0;
  endfunction

  // Set chunk rectangle [x0..x1] x [y0..y1]; report whether any of it is off-window
  function automatic logic mark_chunks(int unsigned lay, int unsigned x0, int unsigned y0,
                                       int unsigned x1, int unsigned y1);
    int unsigned cx, cy;
    logic        clip;
    clip = (x0 < shadow_wx) || (x1 > shadow_wx + GRID - 1) ||
           (y0 < shadow_wy) || (y1 > shadow_wy + GRID - 1);
    for (int r = 0; r < GRID; r++) begin
      cy = shadow_wy + r;
      for (int c = 0; c < GRID; c++) begin
        cx = shadow_wx + c;
        if (cy >= y0 && cy <= y1 && cx >= x0 && cx <= x1)
          shadow_map[lay[3:0]][6'(r * GRID + c)] = 1'b1;
      end
    end
    return clip;
  endfunction

  function automatic void track_cmd(cmd_t cmd);
    int unsigned xa, ya, xb, yb, lay, x0, y0, x1, y1, bit_idx;
    logic        all_prior, clip, ans;
    xa = 32'(cmd.x_a); ya = 32'(cmd.y_a); xb = 32'(cmd.x_b); yb = 32'(cmd.y_b);
    lay = 32'(cmd.layer);
    all_prior = shadow_all;
    case (cmd.operation)
      OP_TILE, OP_NODE, OP_CHUNK, OP_REGION: begin
        if (lay >= LAYERS) begin
          // bad layer: nothing moves
          add_result(KIND_ACK, 1'b0, 1'b0, '0, '0, all_prior, 1'b0, 1'b1);
        end else begin
          if (cmd.operation == OP_TILE) begin
            x0 = xa >> CHUNK_BITS; y0 = ya >> CHUNK_BITS;
            x1 = x0; y1 = y0;
          end else if (cmd.operation == OP_NODE) begin
            x0 = (xa << NODE_BITS) >> CHUNK_BITS; y0 = (ya << NODE_BITS) >> CHUNK_BITS;
            x1 = x0; y1 = y0;
          end else if (cmd.operation == OP_CHUNK) begin
            x0 = xa; y0 = ya; x1 = xa; y1 = ya;
          end else begin
            // corners swapped into order
            x0 = ((xa < xb) ? xa : xb) >> CHUNK_BITS;
            x1 = ((xa < xb) ? xb : xa) >> CHUNK_BITS;
            y0 = ((ya < yb) ? ya : yb) >> CHUNK_BITS;
            y1 = ((ya < yb) ? yb : ya) >> CHUNK_BITS;
          end
          shadow_gen = shadow_gen + 1;
          clip = 1'b0;
          if (!shadow_all) clip = mark_chunks(lay, x0, y0, x1, y1);
          add_result(KIND_ACK, 1'b1, 1'b0, '0, '0, all_prior, clip, 1'b1);
        end
      end
      OP_ALL: begin
        wipe_map();
        shadow_all = 1'b1;
        shadow_gen = shadow_gen + 1;
        add_result(KIND_ACK, 1'b1, 1'b0, '0, '0, all_prior, 1'b0, 1'b1);
      end
      OP_QUERY: begin
        ans = shadow_all;
        if (!shadow_all && lay < LAYERS && xa >= shadow_wx && ya >= shadow_wy &&
            xa - shadow_wx < GRID && ya - shadow_wy < GRID) begin
          bit_idx = (ya - shadow_wy) * GRID + (xa - shadow_wx);
          ans = shadow_map[lay[3:0]][bit_idx[5:0]];
        end
        add_result(KIND_QUERY, 1'b0, ans, '0, '0, all_prior, 1'b0, 1'b1);
      end
      OP_CLEAR: begin
        wipe_map();
        add_result(KIND_ACK, 1'b0, 1'b0, '0, '0, all_prior, 1'b0, 1'b1);
      end
      default: begin
        // take: one word per layer, then empty
        for (int i = 0; i < LAYERS; i++)
          add_result(KIND_WORD, 1'b0, 1'b0, 4'(i), shadow_map[i[3:0]], all_prior, 1'b0,
                     i == LAYERS - 1);
        wipe_map();
        drains_seen++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic string result_text(result_t r);
    return $sformatf("kind=%0d ntf=%b dirty=%b layer=%0d word=%h all=%b gen=%0d clip=%b last=%b",
                     r.kind, r.notified, r.is_dirty, r.drained_layer, r.dirty_word,
                     r.all_dirty, r.generation, r.clipped, r.last);
  endfunction

  function automatic void check_result();
    result_t got, want;
    got.kind = kind; got.notified = notified; got.is_dirty = is_dirty;
    got.drained_layer = drained_layer; got.dirty_word = dirty_word;
    got.all_dirty = all_dirty; got.generation = generation;
    got.clipped = clipped; got.last = last;
    results_checked++;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word: %s", result_text(got));
    end else begin
      want = awaited_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result word %0d differs", results_checked);
          $display("  expected %s", result_text(want));
          $display("  actual   %s", result_text(got));
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      send_fire = in_valid && !in_stall;
      if (send_fire) begin
        track_cmd(cur_cmd);
        cmds_accepted++;
      end
      if (!in_valid || send_fire) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          operation <= cur_cmd.operation;
          x_a <= cur_cmd.x_a; y_a <= cur_cmd.y_a;
          x_b <= cur_cmd.x_b; y_b <= cur_cmd.y_b;
          layer <= cur_cmd.layer;
          in_valid <= 1'b1;
          send_gap <= quiet_send ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
        recv_next = quiet_recv ? 0 : $urandom_range(0, 7);
      end else begin
        recv_next = (recv_wait > 0) ? recv_wait - 1 : 0;
      end
      recv_wait <= recv_next;
      out_stall <= long_hold || (recv_next > 0);
    end
  end

  // Long receiver hold-off once a big batch is waiting, so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) long_hold <= 1'b0;
    end else if (!hold_done && pending_cmds.size() >= 60) begin
      hold_left <= 150;
      long_hold <= 1'b1;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_cmd(op_t op, logic [15:0] xa, logic [15:0] ya, logic [15:0] xb,
                           logic [15:0] yb, logic [4:0] lay);
    cmd_t cmd;
    cmd.operation = op; cmd.x_a = xa; cmd.y_a = ya; cmd.x_b = xb; cmd.y_b = yb;
    cmd.layer = lay;
    pending_cmds.insert(pending_cmds.size(), cmd);
    cmds_queued++;
  endtask

  // Coordinate whose chunk lands in or just around the window, or at times a random one
  function automatic logic [15:0] near_window(int unsigned w, int shift);
    longint c, v;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    c = longint'(w) + longint'($urandom_range(0, GRID + 1)) - 1;
    if (c < 0) c = 0;
    v = (c << shift) + longint'($urandom_range(0, (1 << shift) - 1));
    if (v > 65535) return 16'($urandom);
    return 16'(v);
  endfunction

  task automatic queue_random_cmd();
    int          pick;
    op_t         op;
    logic [4:0]  lay;
    logic [15:0] xa, ya, xb, yb;
    pick = $urandom_range(0, 99);
    if (pick < 18)      op = OP_TILE;
    else if (pick < 32) op = OP_NODE;
    else if (pick < 50) op = OP_CHUNK;
    else if (pick < 66) op = OP_REGION;
    else if (pick < 70) op = OP_ALL;
    else if (pick < 88) op = OP_QUERY;
    else if (pick < 92) op = OP_CLEAR;
    else                op = OP_TAKE;
    if ($urandom_range(0, 9) == 0) lay = 5'($urandom_range(LAYERS, 31));
    else                           lay = 5'($urandom_range(0, LAYERS - 1));
    xb = 16'($urandom);
    yb = 16'($urandom);
    case (op)
      OP_TILE: begin
        xa = near_window(shadow_wx, CHUNK_BITS);
        ya = near_window(shadow_wy, CHUNK_BITS);
      end
      OP_NODE: begin
        xa = near_window(shadow_wx, CHUNK_BITS - NODE_BITS);
        ya = near_window(shadow_wy, CHUNK_BITS - NODE_BITS);
      end
      OP_REGION: begin
        xa = near_window(shadow_wx, CHUNK_BITS);
        ya = near_window(shadow_wy, CHUNK_BITS);
        xb = near_window(shadow_wx, CHUNK_BITS);
        yb = near_window(shadow_wy, CHUNK_BITS);
      end
      default: begin
        xa = near_window(shadow_wx, 0);
        ya = near_window(shadow_wy, 0);
      end
    endcase
    queue_cmd(op, xa, ya, xb, yb, lay);
  endtask

  task automatic set_window_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WINDOW_X) shadow_wx = 32'(val);
    else                     shadow_wy = 32'(val);
    window_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(logic [15:0] wx, logic [15:0] wy);
    set_window_reg(CFG_WINDOW_X, wx);
    set_window_reg(CFG_WINDOW_Y, wy);
  endtask

  // Idle: every queued word accepted and every expected word returned
  task automatic wait_drained();
    while (cmds_accepted != cmds_queued || awaited_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int          n;
    logic [15:0] wx, wy;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: window at origin
    set_window(16'd0, 16'd0);
    queue_cmd(OP_QUERY,  16'd0,      16'd0,      16'd0,  16'd0,  5'd0);
    queue_cmd(OP_TILE,   16'd0,      16'd0,      16'd0,  16'd0,  5'd0);
    queue_cmd(OP_TILE,   16'hFFFF,   16'hFFFF,   16'd0,  16'd0,  5'd15);
    queue_cmd(OP_NODE,   16'd31,     16'd31,     16'd0,  16'd0,  5'd1);
    queue_cmd(OP_NODE,   16'hFFFF,   16'd0,      16'd0,  16'd0,  5'd2);
    queue_cmd(OP_CHUNK,  16'd7,      16'd7,      16'd0,  16'd0,  5'd3);
    queue_cmd(OP_CHUNK,  16'd8,      16'd0,      16'd0,  16'd0,  5'd3);
    // regions, the first with reversed corners covering exactly the window
    queue_cmd(OP_REGION, 16'd255,    16'd255,    16'd0,  16'd0,  5'd4);
    queue_cmd(OP_REGION, 16'd0,      16'd0,      16'hFFFF, 16'hFFFF, 5'd5);
    queue_cmd(OP_REGION, 16'd100,    16'd40,     16'd20, 16'd200, 5'd6);
    // marks on a layer that does not exist
    queue_cmd(OP_TILE,   16'd0,      16'd0,      16'd0,  16'd0,  5'd16);
    queue_cmd(OP_REGION, 16'd0,      16'd0,      16'd255, 16'd255, 5'd31);
    queue_cmd(OP_QUERY,  16'd7,      16'd7,      16'd0,  16'd0,  5'd3);
    queue_cmd(OP_QUERY,  16'd8,      16'd0,      16'd0,  16'd0,  5'd3);
    queue_cmd(OP_TAKE,   16'd0,      16'd0,      16'd0,  16'd0,  5'd0);
    // all-dirty: marks only bump the generation, queries answer the flag
    queue_cmd(OP_ALL,    16'd0,      16'd0,      16'd0,  16'd0,  5'd0);
    queue_cmd(OP_TILE,   16'hFFFF,   16'hFFFF,   16'd0,  16'd0,  5'd0);
    queue_cmd(OP_QUERY,  16'd5,      16'd5,      16'd0,  16'd0,  5'd20);
    queue_cmd(OP_CLEAR,  16'd0,      16'd0,      16'd0,  16'd0,  5'd0);
    queue_cmd(OP_ALL,    16'd0,      16'd0,      16'd0,  16'd0,  5'd0);
    queue_cmd(OP_TAKE,   16'd0,      16'd0,      16'd0,  16'd0,  5'd0);
    queue_cmd(OP_CHUNK,  16'd0,      16'd0,      16'd0,  16'd0,  5'd9);
    wait_drained();

    // directed: window at the far corner; the map stays where it is
    set_window(16'hFFFF, 16'hFFFF);
    queue_cmd(OP_QUERY,  16'hFFFF,   16'hFFFF,   16'd0,  16'd0,  5'd9);
    queue_cmd(OP_CHUNK,  16'hFFFF,   16'hFFFF,   16'd0,  16'd0,  5'd7);
    queue_cmd(OP_CHUNK,  16'hFFFE,   16'hFFFF,   16'd0,  16'd0,  5'd7);
    queue_cmd(OP_REGION, 16'hFFFF,   16'hFFFF,   16'd0,  16'd0,  5'd8);
    queue_cmd(OP_TAKE,   16'd0,      16'd0,      16'd0,  16'd0,  5'd0);
    wait_drained();

    // random phases, each under its own window
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin wx = 16'd0;     wy = 16'd0;     end
        1: begin wx = 16'hFFFF;  wy = 16'd0;     end
        2: begin wx = 16'd0;     wy = 16'($urandom_range(0, 40)); end
        3: begin wx = 16'd2040;  wy = 16'd2040;  end
        4: begin wx = 16'd8184;  wy = 16'd8190;  end
        5: begin wx = 16'($urandom_range(0, 2047)); wy = 16'($urandom_range(0, 2047)); end
        6: begin wx = 16'($urandom); wy = 16'($urandom); end
        default: begin wx = 16'($urandom_range(0, 60)); wy = 16'($urandom_range(0, 60)); end
      endcase
      set_window(wx, wy);
      quiet_send = (ph % 3 == 1) || (ph == 5);
      quiet_recv = (ph % 4 == 2) || (ph == 5);
      n = (ph == 2) ? 90 : 38;
      repeat (n) queue_random_cmd();
      wait_drained();
    end

    // let any stray words show up
    repeat (40) @(posedge clk);
    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("%0d expected result words never arrived", awaited_results.size());
    end
    $display("Ran %0d commands including %0d takes across %0d window register writes;",
             cmds_accepted, drains_seen, window_writes);
    $display("checked %0d result words with random stalls and one long output hold-off",
             results_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
